/* rtl/mps_pkg.sv */
// Shared types and constants of the momentum predictor stencil.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package mps_pkg;

    localparam int DATA_W    = 32;  // velocity fields, signed fixed point
    localparam int GAIN_W    = 31;  // gain registers, unsigned fixed point
    localparam int LAP_W     = 35;  // exact five-point Laplacian
    localparam int SPLIT_W   = 24;  // low slice of a gain multiplication
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADV_GAIN  = 1'b0,
        CFG_DIFF_GAIN = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

/* rtl/momentum_predictor_stencil.sv */
// Predictor stencil: six-stage pipeline from stencil beat to u_star/v_star.
// Depends on mps_pkg (widths, register index codes).
`default_nettype none

// Momentum predictor stencil. Each input beat carries the centre and the four
// neighbour values of u and v for one interior cell (signed fixed point with
// FRAC_BITS fraction bits); each output beat carries u_star and v_star:
//   star = centre - adv_gain * A + diff_gain * L
// where A is the central-difference advection term built from floored face
// averages and floored products, and L is the exact five-point Laplacian.
// Gain products are floored and exact; the result saturates to 32 bits.
// Rate: one beat per clock while the output is not stalled. From input accept
// to output valid, face averages and Laplacian, eight 32x32 products, the
// advection sums, the sliced gain multiplications, their recombination, and
// the final add with saturation each get one register stage. Every stage has
// its own valid bit and ready is chained back stage by stage, so bubbles are
// squeezed out and a stalled output still lets the front of the pipe fill.
// Gains are written through the cfg channel (index 0 advection, 1 diffusion,
// always ready) and must only change while the pipeline is empty.
module momentum_predictor_stencil #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // stencil input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_u_centre,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_u_north,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_u_south,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_u_east,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_u_west,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_v_centre,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_v_north,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_v_south,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_v_east,
    input  wire logic signed [mps_pkg::DATA_W-1:0]    i_v_west,
    // result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [mps_pkg::DATA_W-1:0]         o_u_star,
    output logic signed [mps_pkg::DATA_W-1:0]         o_v_star,
    // configuration write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [mps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mps_pkg::GAIN_W-1:0]           i_cfg_data
);

    localparam int DW    = mps_pkg::DATA_W;
    localparam int GW    = mps_pkg::GAIN_W;
    localparam int LW    = mps_pkg::LAP_W;
    localparam int SW    = mps_pkg::SPLIT_W;
    localparam int PW    = 2 * DW;              // full product of two averages
    localparam int QW    = PW - FRAC_BITS;      // floored product
    localparam int AW    = QW + 2;              // four-term advection sum
    localparam int AHW   = AW - SW;             // high slice of advection term
    localparam int LHW   = LW - SW;             // high slice of Laplacian
    localparam int LOPW  = SW + GW;             // low slice times gain
    localparam int AHPW  = AHW + GW + 1;        // signed high slice times gain
    localparam int LHPW  = LHW + GW + 1;
    localparam int AFW   = AW + GW + 1;         // full advection gain product
    localparam int LFW   = LW + GW + 1;
    localparam int GAW   = AFW - FRAC_BITS;     // scaled advection term
    localparam int GDW   = LFW - FRAC_BITS;     // scaled diffusion term
    localparam int RW    = GAW + 2;             // final sum before saturation

    // ---------------------------------------------------------------
    // Gain registers
    // ---------------------------------------------------------------
    logic [GW-1:0] r_adv_gain;
    logic [GW-1:0] r_diff_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv_gain  <= '0;
            r_diff_gain <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (mps_pkg::t_cfg_idx'(i_cfg_index))
                mps_pkg::CFG_ADV_GAIN:  r_adv_gain  <= i_cfg_data;
                mps_pkg::CFG_DIFF_GAIN: r_diff_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Valid bits and ready chain (stage k loads when rdy[k])
    // ---------------------------------------------------------------
    logic [6:1] r_vld;
    logic [6:1] rdy;

    always_comb begin
        rdy[6] = !r_vld[6] || i_out_ready;
        for (int k = 5; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_in_ready  = rdy[1];
    assign o_out_valid = r_vld[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_in_valid;
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: face averages, Laplacian
    // avg index: 0 un, 1 us, 2 ue, 3 uw, 4 vn, 5 vs, 6 ve, 7 vw
    // ---------------------------------------------------------------
    function automatic logic signed [DW-1:0] avg2(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        return s[DW:1];
    endfunction

    function automatic logic signed [LW-1:0] lap5(input logic signed [DW-1:0] c,
                                                 input logic signed [DW-1:0] n,
                                                 input logic signed [DW-1:0] s,
                                                 input logic signed [DW-1:0] e,
                                                 input logic signed [DW-1:0] w);
        logic signed [LW-1:0] c4;
        c4 = {c[DW-1], c, 2'b00};
        return LW'(e) + LW'(w) + LW'(n) + LW'(s) - c4;
    endfunction

    logic signed [DW-1:0] n_avg [8];
    logic signed [DW-1:0] r_avg [8];
    logic signed [LW-1:0] r_lap1 [2];
    logic signed [DW-1:0] r_ctr1 [2];

    always_comb begin
        n_avg[0] = avg2(i_u_centre, i_u_north);
        n_avg[1] = avg2(i_u_centre, i_u_south);
        n_avg[2] = avg2(i_u_centre, i_u_east);
        n_avg[3] = avg2(i_u_centre, i_u_west);
        n_avg[4] = avg2(i_v_centre, i_v_north);
        n_avg[5] = avg2(i_v_centre, i_v_south);
        n_avg[6] = avg2(i_v_centre, i_v_east);
        n_avg[7] = avg2(i_v_centre, i_v_west);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_avg     <= n_avg;
            r_lap1[0] <= lap5(i_u_centre, i_u_north, i_u_south, i_u_east, i_u_west);
            r_lap1[1] <= lap5(i_v_centre, i_v_north, i_v_south, i_v_east, i_v_west);
            r_ctr1[0] <= i_u_centre;
            r_ctr1[1] <= i_v_centre;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: eight floored products
    // 0 vn*un, 1 vs*us, 2 ue*ue, 3 uw*uw, 4 vn*vn, 5 vs*vs, 6 ue*ve, 7 uw*vw
    // ---------------------------------------------------------------
    logic signed [PW-1:0] n_prod [8];
    logic signed [QW-1:0] r_qp [8];
    logic signed [LW-1:0] r_lap2 [2];
    logic signed [DW-1:0] r_ctr2 [2];

    always_comb begin
        n_prod[0] = r_avg[4] * r_avg[0];
        n_prod[1] = r_avg[5] * r_avg[1];
        n_prod[2] = r_avg[2] * r_avg[2];
        n_prod[3] = r_avg[3] * r_avg[3];
        n_prod[4] = r_avg[4] * r_avg[4];
        n_prod[5] = r_avg[5] * r_avg[5];
        n_prod[6] = r_avg[2] * r_avg[6];
        n_prod[7] = r_avg[3] * r_avg[7];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int j = 0; j < 8; j++) begin
                r_qp[j] <= n_prod[j][PW-1:FRAC_BITS];   // floor by arithmetic slice
            end
            r_lap2 <= r_lap1;
            r_ctr2 <= r_ctr1;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: advection sums
    // ---------------------------------------------------------------
    logic signed [AW-1:0] r_adv3 [2];
    logic signed [LW-1:0] r_lap3 [2];
    logic signed [DW-1:0] r_ctr3 [2];

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_adv3[0] <= AW'(r_qp[0]) - AW'(r_qp[1]) + AW'(r_qp[2]) - AW'(r_qp[3]);
            r_adv3[1] <= AW'(r_qp[4]) - AW'(r_qp[5]) + AW'(r_qp[6]) - AW'(r_qp[7]);
            r_lap3    <= r_lap2;
            r_ctr3    <= r_ctr2;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: gain products, term split into signed high and unsigned
    // low slices so each multiplier stays near 32x32
    // ---------------------------------------------------------------
    logic signed [AHPW-1:0] n_ahp [2];
    logic        [LOPW-1:0] n_alp [2];
    logic signed [LHPW-1:0] n_lhp [2];
    logic        [LOPW-1:0] n_llp [2];
    logic signed [AHPW-1:0] r_ahp [2];
    logic        [LOPW-1:0] r_alp [2];
    logic signed [LHPW-1:0] r_lhp [2];
    logic        [LOPW-1:0] r_llp [2];
    logic signed [DW-1:0]   r_ctr4 [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_ahp[j] = $signed(r_adv3[j][AW-1:SW]) * $signed({1'b0, r_adv_gain});
            n_alp[j] = LOPW'(r_adv3[j][SW-1:0]) * LOPW'(r_adv_gain);
            n_lhp[j] = $signed(r_lap3[j][LW-1:SW]) * $signed({1'b0, r_diff_gain});
            n_llp[j] = LOPW'(r_lap3[j][SW-1:0]) * LOPW'(r_diff_gain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_ahp  <= n_ahp;
            r_alp  <= n_alp;
            r_lhp  <= n_lhp;
            r_llp  <= n_llp;
            r_ctr4 <= r_ctr3;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: recombine slices and floor by FRAC_BITS
    // ---------------------------------------------------------------
    logic signed [AFW-1:0] n_afull [2];
    logic signed [LFW-1:0] n_lfull [2];
    logic signed [GAW-1:0] r_ga [2];
    logic signed [GDW-1:0] r_gd [2];
    logic signed [DW-1:0]  r_ctr5 [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_afull[j] = $signed({r_ahp[j], {SW{1'b0}}}) + $signed(AFW'(r_alp[j]));
            n_lfull[j] = $signed({r_lhp[j], {SW{1'b0}}}) + $signed(LFW'(r_llp[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int j = 0; j < 2; j++) begin
                r_ga[j] <= n_afull[j][AFW-1:FRAC_BITS];
                r_gd[j] <= n_lfull[j][LFW-1:FRAC_BITS];
            end
            r_ctr5 <= r_ctr4;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: centre + diffusion - advection, saturate, output register
    // (the sum is exact, so the advection term needs no separate clamp)
    // ---------------------------------------------------------------
    function automatic logic signed [DW-1:0] sat(input logic signed [RW-1:0] r);
        logic [RW-DW:0] top;
        top = r[RW-1:DW-1];
        if ((&top) || !(|top)) return r[DW-1:0];
        else if (r[RW-1])      return {1'b1, {(DW-1){1'b0}}};
        else                   return {1'b0, {(DW-1){1'b1}}};
    endfunction

    logic signed [RW-1:0] n_sum [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_sum[j] = RW'(r_ctr5[j]) + RW'(r_gd[j]) - RW'(r_ga[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            o_u_star <= sat(n_sum[0]);
            o_v_star <= sat(n_sum[1]);
        end
    end

endmodule

`default_nettype wire

/* rtl/mps_checker.sv */
// Port-level checker for the momentum predictor stencil, bound to the top.
// Depends on mps_pkg (field widths).
`default_nettype none

module mps_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_in_ready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [mps_pkg::DATA_W-1:0] o_u_star,
    input wire logic signed [mps_pkg::DATA_W-1:0] o_v_star
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_u_star) && $stable(o_v_star))
        else $error("result payload changed while stalled");

    // input backpressure only arises from a stalled output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with output free");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind momentum_predictor_stencil mps_checker u_mps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_u_star    (o_u_star),
    .o_v_star    (o_v_star)
);

`default_nettype wire

/* tb/sv/mps_tb_pkg.sv */
// Stencil and result beat types plus the u_star/v_star scoreboard.
// Depends on mps_pkg (field widths, register index codes).
`timescale 1ns / 1ps

package mps_tb_pkg;

    localparam int     FRAC      = 24;
    localparam longint SAT_HI    = 64'sd2147483647;
    localparam longint SAT_LO    = -64'sd2147483648;
    localparam longint ADV_CLAMP = 64'sd1 <<< 60;

    typedef logic signed [mps_pkg::DATA_W-1:0] t_vel;
    typedef logic signed [127:0]               t_wide;

    typedef struct {
        t_vel u_c, u_n, u_s, u_e, u_w;
        t_vel v_c, v_n, v_s, v_e, v_w;
    } t_stencil;

    typedef struct {
        t_vel u_star;
        t_vel v_star;
    } t_star;

    class momentum_scoreboard;

        logic [mps_pkg::GAIN_W-1:0] adv_gain;
        logic [mps_pkg::GAIN_W-1:0] diff_gain;
        t_star                      star_expected[$];
        int                         mismatches;

        function new();
            adv_gain    = '0;
            diff_gain   = '0;
            mismatches  = 0;
        endfunction

        function void set_gain(mps_pkg::t_cfg_idx idx, logic [mps_pkg::GAIN_W-1:0] g);
            case (idx)
                mps_pkg::CFG_ADV_GAIN:  adv_gain  = g;
                mps_pkg::CFG_DIFF_GAIN: diff_gain = g;
                default: ;
            endcase
        endfunction

        function int pending();
            return star_expected.size();
        endfunction

        // floor of the face average, sum kept exact
        function longint face_avg(longint a, longint b);
            return (a + b) >>> 1;
        endfunction

        // product of two averages floored to the fraction width
        function longint fx_mul(longint a, longint b);
            return (a * b) >>> FRAC;
        endfunction

        function t_wide apply_gain(longint term, logic [mps_pkg::GAIN_W-1:0] g);
            t_wide t;
            t_wide gw;
            t  = t_wide'(term);
            gw = {{(128-mps_pkg::GAIN_W){1'b0}}, g};
            return (t * gw) >>> FRAC;
        endfunction

        function t_vel combine(longint centre, longint adv, longint lap);
            t_wide a;
            t_wide d;
            t_wide r;
            a = apply_gain(adv, adv_gain);
            d = apply_gain(lap, diff_gain);
            if (a > t_wide'(ADV_CLAMP))
                a = t_wide'(ADV_CLAMP);
            if (a < -t_wide'(ADV_CLAMP))
                a = -t_wide'(ADV_CLAMP);
            r = t_wide'(centre) + d - a;
            if (r > t_wide'(SAT_HI))
                r = t_wide'(SAT_HI);
            if (r < t_wide'(SAT_LO))
                r = t_wide'(SAT_LO);
            return r[mps_pkg::DATA_W-1:0];
        endfunction

        function t_star predict_star(t_stencil s);
            longint uc, vc, un, us, ue, uw, vn, vs, ve, vw;
            longint adv_u, adv_v, lap_u, lap_v;
            t_star  res;
            uc = longint'(s.u_c);
            vc = longint'(s.v_c);
            un = face_avg(uc, longint'(s.u_n));
            us = face_avg(uc, longint'(s.u_s));
            ue = face_avg(uc, longint'(s.u_e));
            uw = face_avg(uc, longint'(s.u_w));
            vn = face_avg(vc, longint'(s.v_n));
            vs = face_avg(vc, longint'(s.v_s));
            ve = face_avg(vc, longint'(s.v_e));
            vw = face_avg(vc, longint'(s.v_w));
            adv_u = fx_mul(vn, un) - fx_mul(vs, us) + fx_mul(ue, ue) - fx_mul(uw, uw);
            adv_v = fx_mul(vn, vn) - fx_mul(vs, vs) + fx_mul(ue, ve) - fx_mul(uw, vw);
            lap_u = longint'(s.u_e) + longint'(s.u_w) + longint'(s.u_n)
                    + longint'(s.u_s) - 4 * uc;
            lap_v = longint'(s.v_e) + longint'(s.v_w) + longint'(s.v_n)
                    + longint'(s.v_s) - 4 * vc;
            res.u_star = combine(uc, adv_u, lap_u);
            res.v_star = combine(vc, adv_v, lap_v);
            return res;
        endfunction

        function void note_stencil(t_stencil s);
            star_expected.push_back(predict_star(s));
        endfunction

        task report(string what);
            $display("MISMATCH %s", what);
            mismatches++;
        endtask

        task check_star(t_vel u_got, t_vel v_got);
            t_star exp_star;
            if (star_expected.size() == 0) begin
                report($sformatf("result beat with nothing pending: u=%0d v=%0d",
                                 u_got, v_got));
                return;
            end
            exp_star = star_expected.pop_front();
            if (u_got !== exp_star.u_star)
                report($sformatf("u_star got %0d expected %0d", u_got, exp_star.u_star));
            if (v_got !== exp_star.v_star)
                report($sformatf("v_star got %0d expected %0d", v_got, exp_star.v_star));
        endtask

    endclass

endpackage

/* tb/sv/tb.sv */
// Top-level testbench of the momentum predictor stencil: drives stencil beats
// and gain writes, paces the result side, checks every u_star/v_star beat.
// Depends on mps_pkg and mps_tb_pkg.
`timescale 1ns / 1ps

module tb;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic i_in_valid;
    logic o_in_ready;
    mps_tb_pkg::t_vel i_u_centre, i_u_north, i_u_south, i_u_east, i_u_west;
    mps_tb_pkg::t_vel i_v_centre, i_v_north, i_v_south, i_v_east, i_v_west;

    logic o_out_valid;
    logic i_out_ready;
    mps_tb_pkg::t_vel o_u_star, o_v_star;

    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [mps_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mps_pkg::GAIN_W-1:0]    i_cfg_data;

    mps_tb_pkg::momentum_scoreboard sb = new();

    momentum_predictor_stencil u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_u_centre  (i_u_centre),
        .i_u_north   (i_u_north),
        .i_u_south   (i_u_south),
        .i_u_east    (i_u_east),
        .i_u_west    (i_u_west),
        .i_v_centre  (i_v_centre),
        .i_v_north   (i_v_north),
        .i_v_south   (i_v_south),
        .i_v_east    (i_v_east),
        .i_v_west    (i_v_west),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_u_star    (o_u_star),
        .o_v_star    (o_v_star),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Monitors: everything is sampled at the rising edge. Inputs only move
    // at the falling edge, so each handshake is seen exactly once.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_gain(mps_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_stencil('{i_u_centre, i_u_north, i_u_south, i_u_east, i_u_west,
                                  i_v_centre, i_v_north, i_v_south, i_v_east, i_v_west});
            if (o_out_valid && i_out_ready)
                sb.check_star(o_u_star, o_v_star);
        end
    end

    // Idle length: mostly short, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(99, 0) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ---------------------------------------------------------------------
    // Result-side pacing. The stall rate is redrawn whenever a mode runs out, and
    // one of the modes never stalls, so the pipe sees both full-rate runs
    // and back-pressure landing on every stage.
    // ---------------------------------------------------------------------
    initial begin : sink_pacing
        int stall_left;
        int mode_left;
        int stall_pct;
        stall_left  = 0;
        mode_left   = 0;
        stall_pct   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode_left = $urandom_range(200, 20);
                case ($urandom_range(3, 0))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(99, 0) < stall_pct) begin
                stall_left = gap_len() - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus values
    // ---------------------------------------------------------------------

    // Velocity of random magnitude; now and then full range or an extreme.
    function automatic mps_tb_pkg::t_vel rand_vel();
        mps_tb_pkg::t_vel raw;
        raw = $urandom();
        case ($urandom_range(9, 0))
            0: return raw;
            1: begin
                case ($urandom_range(3, 0))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return raw >>> $urandom_range(30, 4);
        endcase
    endfunction

    // Signed offset below 2^spread, for neighbours close to the centre.
    function automatic mps_tb_pkg::t_vel near(int unsigned spread);
        mps_tb_pkg::t_vel raw;
        raw = $urandom();
        return raw >>> (31 - spread);
    endfunction

    // Mostly smooth fields (neighbours near the centre, as in a real flow),
    // the rest independent values of random size and raw noise.
    function automatic mps_tb_pkg::t_stencil rand_stencil();
        mps_tb_pkg::t_stencil s;
        int unsigned          kind;
        int unsigned          spread;
        kind = $urandom_range(99, 0);
        if (kind < 60) begin
            spread = $urandom_range(26, 2);
            s.u_c = rand_vel();
            s.v_c = rand_vel();
            s.u_n = s.u_c + near(spread);
            s.u_s = s.u_c + near(spread);
            s.u_e = s.u_c + near(spread);
            s.u_w = s.u_c + near(spread);
            s.v_n = s.v_c + near(spread);
            s.v_s = s.v_c + near(spread);
            s.v_e = s.v_c + near(spread);
            s.v_w = s.v_c + near(spread);
        end else if (kind < 85) begin
            s = '{rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(),
                  rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel()};
        end else begin
            s = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        end
        return s;
    endfunction

    // Gain of random size: zero, one lsb, full scale, or anything between.
    function automatic logic [mps_pkg::GAIN_W-1:0] rand_gain();
        logic [31:0]                r32;
        logic [mps_pkg::GAIN_W-1:0] raw;
        r32 = $urandom();
        raw = r32[mps_pkg::GAIN_W-1:0];
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return 31'd1;
            2:       return '1;
            default: return raw >> $urandom_range(30, 0);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // One stencil beat, optionally after some idle cycles. Valid gets a
    // single assignment per falling edge, so back-to-back beats keep it high.
    task automatic send_stencil(mps_tb_pkg::t_stencil s, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_u_centre <= s.u_c;
        i_u_north  <= s.u_n;
        i_u_south  <= s.u_s;
        i_u_east   <= s.u_e;
        i_u_west   <= s.u_w;
        i_v_centre <= s.v_c;
        i_v_north  <= s.v_n;
        i_v_south  <= s.v_s;
        i_v_east   <= s.v_e;
        i_v_west   <= s.v_w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Both gain registers, back to back on the cfg channel.
    task automatic write_gains(logic [mps_pkg::GAIN_W-1:0] adv,
                               logic [mps_pkg::GAIN_W-1:0] diff);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= mps_pkg::CFG_ADV_GAIN;
        i_cfg_data  <= adv;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= mps_pkg::CFG_DIFF_GAIN;
        i_cfg_data  <= diff;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Gains may only change with the pipe empty.
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Directed beats: extremes, sign mixes, floor rounding of negative odd
    // sums, a realistic smooth cell, and a Laplacian pushed to both ends.
    // ---------------------------------------------------------------------
    mps_tb_pkg::t_stencil directed[$];

    task automatic build_directed();
        mps_tb_pkg::t_vel mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        directed = {};
        directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx});
        directed.push_back('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn});
        directed.push_back('{mx, mn, mn, mn, mn, mn, mx, mx, mx, mx});
        directed.push_back('{mn, mx, mx, mx, mx, mx, mn, mn, mn, mn});
        directed.push_back('{-1, 0, 0, 0, 0, -1, 0, 0, 0, 0});
        // u around 1.0, v around -0.5
        directed.push_back('{32'sh0100_0000, 32'sh0180_0000, 32'sh0080_0000,
                             32'sh0140_0000, 32'sh00C0_0000,
                             -32'sh0080_0000, -32'sh0040_0000, -32'sh00C0_0000,
                             -32'sh0060_0000, -32'sh00A0_0000});
        directed.push_back('{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                             32'sh5555_5555, 32'shAAAA_AAAA,
                             32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                             32'shAAAA_AAAA, 32'sh5555_5555});
        directed.push_back('{mx, mx, mx, mx, mx, mn, mn, mn, mn, mn});
        directed.push_back('{1, -1, 1, -1, 3, -1, 1, -3, 1, -1});
        directed.push_back('{0, mx, mx, mx, mx, 0, mx, mx, mx, mx});
        directed.push_back('{0, mn, mn, mn, mn, 0, mn, mn, mn, mn});
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    localparam int RAND_PHASES = 6;
    localparam int PHASE_BEATS = 75;

    initial begin : main_seq
        int src_gap_pct;
        logic [mps_pkg::GAIN_W-1:0] adv_set;
        logic [mps_pkg::GAIN_W-1:0] diff_set;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_u_centre  = '0;
        i_u_north   = '0;
        i_u_south   = '0;
        i_u_east    = '0;
        i_u_west    = '0;
        i_v_centre  = '0;
        i_v_north   = '0;
        i_v_south   = '0;
        i_v_east    = '0;
        i_v_west    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = mps_pkg::CFG_ADV_GAIN;
        i_cfg_data  = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        build_directed();

        // gains still at reset (zero): every result must equal its centre
        foreach (directed[k])
            send_stencil(directed[k], 0);
        end_burst();
        drain();

        // same beats under moderate gains, roughly 0.1 and 0.2
        write_gains(31'h0019_9999, 31'h0033_3333);
        foreach (directed[k])
            send_stencil(directed[k], (k % 3 == 2) ? gap_len() : 0);
        end_burst();
        drain();

        // random phases, first four pin the gain extremes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin adv_set = '1;      diff_set = '1;      end
                1: begin adv_set = '0;      diff_set = '1;      end
                2: begin adv_set = '1;      diff_set = '0;      end
                3: begin adv_set = 31'd1;   diff_set = 31'd1;   end
                default: begin
                    adv_set  = rand_gain();
                    diff_set = rand_gain();
                end
            endcase
            write_gains(adv_set, diff_set);
            src_gap_pct = 0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // source idling rate changes every 25 beats
                if (n % 25 == 0) begin
                    case ($urandom_range(2, 0))
                        0:       src_gap_pct = 0;
                        1:       src_gap_pct = 10;
                        default: src_gap_pct = 35;
                    endcase
                end
                send_stencil(rand_stencil(),
                             ($urandom_range(99, 0) < src_gap_pct) ? gap_len() : 0);
            end
            end_burst();
            drain();
        end

        // pipe is six deep; give it a little more before calling it
        repeat (12) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/mps_pkg.sv
rtl/momentum_predictor_stencil.sv
rtl/mps_checker.sv
tb/sv/mps_tb_pkg.sv
tb/sv/tb.sv
